/* rtl/lfcp_pkg.sv */
// Shared types and constants for the LED frame command parser.
`default_nettype none

package lfcp_pkg;

  // Number of header bytes that must match, counted from the first one.
  localparam int HEADER_LENGTH = 4;

  localparam logic [7:0] HDR_CHAR_S = 8'h73;
  localparam logic [7:0] HDR_CHAR_E = 8'h65;
  localparam logic [7:0] HDR_CHAR_N = 8'h6E;
  localparam logic [7:0] HDR_CHAR_D = 8'h64;

  // Command codes.
  localparam logic [7:0] CMD_LIGHT = 8'h00;
  localparam logic [7:0] CMD_OFF   = 8'h02;

  localparam logic [8:0] LED_COUNT_RESET = 9'd82;

  typedef struct packed {
    logic       write_pixel;
    logic [7:0] pixel_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       clear_all;
    logic       show_frame;
    logic       send_ack;
  } lfcp_result_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = HDR_CHAR_S;
      2'd1:    b = HDR_CHAR_E;
      2'd2:    b = HDR_CHAR_N;
      default: b = HDR_CHAR_D;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/led_frame_command_parser_top.sv */
// Top level of the LED frame command parser: input register, parser, result register.
// Items pass from the input register through the parser into the result register.
// Throughput: one item per cycle while out_stall is low; each byte produces exactly
// one result item. The rate is set by the single parse step between the input and
// result registers. Reset (rst_n, synchronous, active low) empties both registers,
// returns the parser to header hunting and sets the LED count register to 82.
`default_nettype none

module led_frame_command_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration: active LED count.
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data,
  // Input channel: one received serial byte per item.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_write_pixel,
  output logic [7:0]      out_pixel_index,
  output logic [7:0]      out_red_level,
  output logic [7:0]      out_green_level,
  output logic [7:0]      out_blue_level,
  output logic            out_clear_all,
  output logic            out_show_frame,
  output logic            out_send_ack
);
  import lfcp_pkg::*;

  logic [8:0]   led_cnt_r;
  logic         in_vld_r, in_vld_nxt;
  logic [7:0]   in_byte_r;
  logic         out_ready;
  logic         advance;
  logic         in_accept;
  lfcp_result_t parse_res;
  lfcp_result_t out_data;

  // Write the configuration register only while idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_cnt_r <= LED_COUNT_RESET;
    end else if (cfg_wr_en) begin
      led_cnt_r <= cfg_wr_data;
    end
  end

  // The held item moves on whenever the result register can take it; the input
  // register refills in the same cycle, so back-to-back items flow without gaps.
  assign advance   = in_vld_r && out_ready;
  assign in_stall  = in_vld_r && !out_ready;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // The parser state advances exactly once per item handed to the result register.
  lfcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .rx_byte   (in_byte_r),
    .led_count (led_cnt_r),
    .result    (parse_res)
  );

  lfcp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_vld_r),
    .load_data  (parse_res),
    .load_ready (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_write_pixel = out_data.write_pixel;
  assign out_pixel_index = out_data.pixel_index;
  assign out_red_level   = out_data.red_level;
  assign out_green_level = out_data.green_level;
  assign out_blue_level  = out_data.blue_level;
  assign out_clear_all   = out_data.clear_all;
  assign out_show_frame  = out_data.show_frame;
  assign out_send_ack    = out_data.send_ack;

`ifndef SYNTHESIS
  // A parsed item always lands in the result register.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("parsed item did not reach the result register");

  // With both registers full and the output stalled, the held item is kept.
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_valid && out_stall) |=> in_vld_r)
    else $error("held input item lost under output stall");

  // Clear-all only comes with acknowledge and show.
  a_clear_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_clear_all == out_send_ack) && (!out_clear_all || out_show_frame)))
    else $error("clear_all without ack and show");

  // Without a pixel write the pixel fields are zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_pixel) |->
      (out_pixel_index == 8'd0 && out_red_level == 8'd0 &&
       out_green_level == 8'd0 && out_blue_level == 8'd0))
    else $error("pixel fields nonzero without write");
`endif

endmodule

`default_nettype wire

/* rtl/lfcp_parser.sv */
// Byte-level parse state machine that turns one byte into one result.
`default_nettype none

module lfcp_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [8:0]          led_count,
  output lfcp_pkg::lfcp_result_t   result
);
  import lfcp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_COMMAND = 3'd2,
    PH_COUNT   = 3'd3,
    PH_RECORD  = 3'd4
  } phase_t;

  localparam logic [2:0] HDR_LEN = 3'(HEADER_LENGTH);

  phase_t     phase_r, phase_nxt;
  logic [1:0] hdr_pos_r, hdr_pos_nxt;
  logic [7:0] recs_left_r, recs_left_nxt;
  logic [1:0] rec_pos_r, rec_pos_nxt;
  logic [7:0] held_idx_r, held_idx_nxt;
  logic [7:0] held_red_r, held_red_nxt;
  logic [7:0] held_grn_r, held_grn_nxt;
  logic [2:0] hdr_pos_inc;
  logic [7:0] recs_dec;

  assign hdr_pos_inc = {1'b0, hdr_pos_r} + 3'd1;
  assign recs_dec    = recs_left_r - 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_pos_nxt   = hdr_pos_r;
    recs_left_nxt = recs_left_r;
    rec_pos_nxt   = rec_pos_r;
    held_idx_nxt  = held_idx_r;
    held_red_nxt  = held_red_r;
    held_grn_nxt  = held_grn_r;
    result        = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (rx_byte == hdr_byte(hdr_pos_r)) begin
          if (hdr_pos_inc >= HDR_LEN) begin
            phase_nxt   = PH_COMMAND;
            hdr_pos_nxt = 2'd0;
          end else begin
            hdr_pos_nxt = hdr_pos_inc[1:0];
          end
        end else begin
          // The mismatching byte is dropped, not retried as a header start.
          phase_nxt   = PH_HUNT;
          hdr_pos_nxt = 2'd0;
        end
      end
      PH_COMMAND: begin
        if (rx_byte == CMD_LIGHT) begin
          phase_nxt = PH_COUNT;
        end else begin
          result.clear_all  = (rx_byte == CMD_OFF);
          result.send_ack   = (rx_byte == CMD_OFF);
          result.show_frame = 1'b1;
          phase_nxt         = PH_HUNT;
        end
      end
      PH_COUNT: begin
        recs_left_nxt = rx_byte;
        rec_pos_nxt   = 2'd0;
        if (rx_byte == 8'd0) begin
          result.show_frame = 1'b1;
          phase_nxt         = PH_HUNT;
        end else begin
          phase_nxt = PH_RECORD;
        end
      end
      PH_RECORD: begin
        rec_pos_nxt = rec_pos_r + 2'd1;
        case (rec_pos_r)
          2'd0: held_idx_nxt = rx_byte;
          2'd1: held_red_nxt = rx_byte;
          2'd2: held_grn_nxt = rx_byte;
          default: begin
            if ({1'b0, held_idx_r} < led_count) begin
              result.write_pixel = 1'b1;
              result.pixel_index = held_idx_r;
              result.red_level   = held_red_r;
              result.green_level = held_grn_r;
              result.blue_level  = rx_byte;
            end
            recs_left_nxt = recs_dec;
            if (recs_dec == 8'd0) begin
              result.show_frame = 1'b1;
              phase_nxt         = PH_HUNT;
            end
          end
        endcase
      end
      default: begin
        // Hunting, and any unused phase code, looks for the first header byte.
        phase_nxt   = PH_HUNT;
        hdr_pos_nxt = 2'd0;
        if (rx_byte == HDR_CHAR_S) begin
          if (HDR_LEN <= 3'd1) begin
            phase_nxt = PH_COMMAND;
          end else begin
            phase_nxt   = PH_HEADER;
            hdr_pos_nxt = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hdr_pos_r   <= 2'd0;
      recs_left_r <= 8'd0;
      rec_pos_r   <= 2'd0;
      held_idx_r  <= 8'd0;
      held_red_r  <= 8'd0;
      held_grn_r  <= 8'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      recs_left_r <= recs_left_nxt;
      rec_pos_r   <= rec_pos_nxt;
      held_idx_r  <= held_idx_nxt;
      held_red_r  <= held_red_nxt;
      held_grn_r  <= held_grn_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lfcp_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
`default_nettype none

module lfcp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load_valid,
  input  wire lfcp_pkg::lfcp_result_t load_data,
  output logic                     load_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lfcp_pkg::lfcp_result_t   out_data
);
  import lfcp_pkg::*;

  logic         valid_r;
  lfcp_result_t data_r;

  // The register takes a new result whenever it is empty or being drained.
  assign load_ready = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire
